### rtl/pswa_pkg.sv
`default_nettype none

package pswa_pkg;

  // command codes
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // fixed field widths of the two channels
  localparam int unsigned SAMPLE_IN_W = 12;
  localparam int unsigned BIN_IN_W    = 5;
  localparam int unsigned AVG_W       = 20;
  localparam int unsigned BINS_W      = 6;
  localparam int unsigned FRAMES_W    = 16;

  // fraction bits of the average
  localparam int unsigned FRAC_W = 8;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [SAMPLE_IN_W-1:0] sample_value;
    logic                   frame_last;
    logic [BIN_IN_W-1:0]    bin_index;
  } pswa_cmd_t;

  typedef struct packed {
    logic [AVG_W-1:0]    average_q8;
    logic [BINS_W-1:0]   bins_in_use;
    logic [FRAMES_W-1:0] frames_added;
    logic                count_saturated;
  } pswa_res_t;

endpackage

`default_nettype wire

### rtl/pedestal_subtracted_waveform_averager.sv
`default_nettype none

// Pedestal-subtracted waveform averager. Each push item stores one sample of
// the current frame in a frame buffer memory and tracks the frame minimum.
// A push with frame_last closes the frame. The minimum is subtracted from
// every buffered sample, and the difference is added to that bin's entry in
// the accumulator memory, one bin per cycle. The close walks the frame in
// S_WALK after the push, paced by the single accumulator write port.
// Samples past MAX_BINS are dropped but still count toward the minimum.
// A read item returns floor(acc * 256 / count) through a restoring divider
// that yields one quotient bit per cycle. The read passes through the
// accumulator memory read, a divider load in S_LOAD, SAMPLE_BITS + 8
// quotient bits in S_DIV, and the move into the output register in S_OUT.
// The next item is taken once the result has moved in. The average is 0
// when no frame was added or the bin is past MAX_BINS. Once the frame
// count is at its maximum, further frames are dropped and count_saturated
// is set. Clear (and reset) zero the accumulator memory with a sweep over
// all MAX_BINS entries, during which no item is taken. Pushes continue
// while a result waits at the output register. A finished read that finds
// the output register still full holds there, and no item is taken until
// its result moves in.
module pedestal_subtracted_waveform_averager #(
  parameter int unsigned MAX_BINS    = 32,
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       cmd_valid,
  output logic                      cmd_ready,
  input  wire pswa_pkg::pswa_cmd_t  cmd,
  output logic                      res_valid,
  input  wire                       res_ready,
  output pswa_pkg::pswa_res_t       res
);
  import pswa_pkg::*;

  localparam int unsigned IDX_W   = $clog2(MAX_BINS);
  localparam int unsigned FILL_W  = $clog2(MAX_BINS + 1);
  localparam int unsigned ACC_W   = SAMPLE_BITS + COUNT_BITS;
  localparam int unsigned Q_W     = SAMPLE_BITS + FRAC_W;   // quotient bits
  localparam int unsigned STEP_W  = $clog2(Q_W);
  localparam int unsigned SMP_IN  = (SAMPLE_BITS < SAMPLE_IN_W) ? SAMPLE_BITS : SAMPLE_IN_W;
  localparam int unsigned BSEL_W  = (IDX_W + 1 > BIN_IN_W) ? IDX_W + 1 : BIN_IN_W;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,  // zero sweep over the accumulators
    S_IDLE  = 6'b000010,  // taking items
    S_WALK  = 6'b000100,  // frame close, read-modify-write per bin
    S_LOAD  = 6'b001000,  // accumulator read data arrives
    S_DIV   = 6'b010000,  // one quotient bit per cycle
    S_OUT   = 6'b100000   // hand result to output register
  } state_t;

  state_t state;

  // memories
  logic [SAMPLE_BITS-1:0] frame_buf [MAX_BINS];
  logic [ACC_W-1:0]       acc_mem   [MAX_BINS];

  logic                   buf_we;
  logic [IDX_W-1:0]       buf_wa;
  logic [SAMPLE_BITS-1:0] buf_wd;
  logic [SAMPLE_BITS-1:0] buf_rd;

  logic                   acc_we;
  logic [IDX_W-1:0]       acc_wa;
  logic [ACC_W-1:0]       acc_wd;
  logic [IDX_W-1:0]       acc_ra;
  logic [ACC_W-1:0]       acc_rd;

  // block state
  logic [COUNT_BITS-1:0]  frame_count;
  logic [FILL_W-1:0]      longest;
  logic [FILL_W-1:0]      fill_pos;
  logic [SAMPLE_BITS-1:0] frame_min;
  logic                   sat_flag;

  // walk / sweep control
  logic [FILL_W-1:0]      walk_idx;
  logic                   rd_pend;
  logic [IDX_W-1:0]       rd_addr;
  logic [IDX_W-1:0]       clr_idx;

  // divider
  logic [COUNT_BITS-1:0]  rem;
  logic [Q_W-1:0]         dsr;      // dividend bits out at top, quotient bits in
  logic [STEP_W-1:0]      step;
  logic                   rd_zero;

  // decoded command
  logic                   accept;
  logic [SAMPLE_BITS-1:0] smp;
  logic [BSEL_W-1:0]      bin_ext;
  logic                   bin_ok;
  logic                   fill_room;
  logic [FILL_W-1:0]      fill_after;
  logic [SAMPLE_BITS-1:0] min_after;
  logic [SAMPLE_BITS-1:0] diff;
  logic [COUNT_BITS:0]    rem_sh;
  logic                   q_bit;

  assign cmd_ready  = (state == S_IDLE);
  assign accept     = cmd_valid && cmd_ready;

  assign smp        = SAMPLE_BITS'(cmd.sample_value[SMP_IN-1:0]);
  assign bin_ext    = BSEL_W'(cmd.bin_index);
  assign bin_ok     = bin_ext < BSEL_W'(MAX_BINS);
  assign fill_room  = fill_pos < FILL_W'(MAX_BINS);
  assign fill_after = fill_room ? fill_pos + FILL_W'(1) : fill_pos;
  assign min_after  = (smp < frame_min) ? smp : frame_min;

  assign diff       = buf_rd - frame_min;
  assign rem_sh     = {rem, dsr[Q_W-1]};
  assign q_bit      = rem_sh >= {1'b0, frame_count};

  // memory port control
  always_comb begin
    buf_we = accept && (cmd.opcode == OP_PUSH) && fill_room;
    buf_wa = fill_pos[IDX_W-1:0];
    buf_wd = smp;

    acc_we = 1'b0;
    acc_wa = rd_addr;
    acc_wd = acc_rd + ACC_W'(diff);
    if (state == S_CLEAR) begin
      acc_we = 1'b1;
      acc_wa = clr_idx;
      acc_wd = '0;
    end else if (state == S_WALK && rd_pend) begin
      acc_we = 1'b1;
    end

    acc_ra = (state == S_IDLE) ? bin_ext[IDX_W-1:0] : walk_idx[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      frame_buf[buf_wa] <= buf_wd;
    end
    buf_rd <= frame_buf[walk_idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_wa] <= acc_wd;
    end
    acc_rd <= acc_mem[acc_ra];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_idx     <= '0;
      frame_count <= '0;
      longest     <= '0;
      fill_pos    <= '0;
      frame_min   <= '1;
      sat_flag    <= 1'b0;
      walk_idx    <= '0;
      rd_pend     <= 1'b0;
      step        <= '0;
      rd_zero     <= 1'b0;
    end else begin
      rd_pend <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (clr_idx == IDX_W'(MAX_BINS - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_idx <= clr_idx + IDX_W'(1);
          end
        end

        S_IDLE: begin
          if (accept) begin
            case (cmd.opcode)
              OP_PUSH: begin
                if (cmd.frame_last) begin
                  if (frame_count == '1) begin
                    // full count: drop the frame
                    sat_flag  <= 1'b1;
                    fill_pos  <= '0;
                    frame_min <= '1;
                  end else begin
                    frame_count <= frame_count + COUNT_BITS'(1);
                    if (fill_after > longest) begin
                      longest <= fill_after;
                    end
                    fill_pos  <= fill_after;
                    frame_min <= min_after;
                    walk_idx  <= '0;
                    state     <= S_WALK;
                  end
                end else begin
                  fill_pos  <= fill_after;
                  frame_min <= min_after;
                end
              end
              OP_READ: begin
                rd_zero <= (frame_count == '0) || !bin_ok;
                state   <= S_LOAD;
              end
              OP_CLEAR: begin
                frame_count <= '0;
                longest     <= '0;
                sat_flag    <= 1'b0;
                fill_pos    <= '0;
                frame_min   <= '1;
                clr_idx     <= '0;
                state       <= S_CLEAR;
              end
              default: ;
            endcase
          end
        end

        S_WALK: begin
          if (walk_idx < fill_pos) begin
            rd_pend  <= 1'b1;
            rd_addr  <= walk_idx[IDX_W-1:0];
            walk_idx <= walk_idx + FILL_W'(1);
          end else begin
            // last write-back happens this cycle
            fill_pos  <= '0;
            frame_min <= '1;
            state     <= S_IDLE;
          end
        end

        S_LOAD: begin
          rem   <= acc_rd[ACC_W-1:SAMPLE_BITS];
          dsr   <= {acc_rd[SAMPLE_BITS-1:0], {FRAC_W{1'b0}}};
          step  <= '0;
          state <= S_DIV;
        end

        S_DIV: begin
          rem  <= q_bit ? COUNT_BITS'(rem_sh - {1'b0, frame_count})
                        : rem_sh[COUNT_BITS-1:0];
          dsr  <= {dsr[Q_W-2:0], q_bit};
          step <= step + STEP_W'(1);
          if (step == STEP_W'(Q_W - 1)) begin
            state <= S_OUT;
          end
        end

        S_OUT: begin
          if (!res_valid || res_ready) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_OUT && (!res_valid || res_ready)) begin
      res_valid           <= 1'b1;
      res.average_q8      <= rd_zero ? '0 : AVG_W'(dsr);
      res.bins_in_use     <= BINS_W'(longest);
      res.frames_added    <= FRAMES_W'(frame_count);
      res.count_saturated <= sat_flag;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_pos <= FILL_W'(MAX_BINS))
    else $error("fill position past MAX_BINS");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (walk_idx <= fill_pos))
    else $error("walk index past frame length");

  a_min_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && $past(state == S_WALK)) |-> $stable(frame_min))
    else $error("pedestal changed during frame close");

  a_res_src: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == S_OUT))
    else $error("result loaded outside divider finish");

  a_acc_addr: assert property (@(posedge clk) disable iff (rst)
    acc_we |-> (acc_wa <= IDX_W'(MAX_BINS - 1)))
    else $error("accumulator write out of range");

endmodule

`default_nettype wire
